// File: rtl/bhpq_pkg.sv
// ----------------------------------------------------------------------------
// bhpq_pkg
// Shared types, constants and the control store of the heap priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package bhpq_pkg;

	localparam int BHPQ_CAPACITY   = 256;
	localparam int BHPQ_ENTRY_BITS = 64;
	localparam int FIELD_W         = 32;
	localparam int COUNT_W         = 9;

	typedef enum logic [1:0] {
		STAT_DONE  = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} bhpq_status_t;

	typedef enum logic {
		KIND_PUSH = 1'b0,
		KIND_POP  = 1'b1
	} bhpq_kind_t;

	typedef struct packed {
		bhpq_kind_t         kind;
		logic [FIELD_W-1:0] key;
		logic [FIELD_W-1:0] payload;
	} bhpq_req_t;

	typedef struct packed {
		bhpq_status_t       status;
		logic [FIELD_W-1:0] popped_key;
		logic [FIELD_W-1:0] popped_payload;
		logic               top_valid;
		logic [FIELD_W-1:0] top_key;
		logic [FIELD_W-1:0] top_payload;
		logic [COUNT_W-1:0] entry_count;
	} bhpq_rsp_t;

	// Datapath actions, one per control word.
	typedef enum logic [3:0] {
		OP_NOP,
		OP_FETCH,
		OP_PUSH_INIT,
		OP_RD_PARENT,
		OP_UP_STEP,
		OP_PLACE,
		OP_POP_INIT,
		OP_LOAD_CUR,
		OP_RD_CHILD,
		OP_DN_STEP,
		OP_SET_FULL,
		OP_SET_EMPTY,
		OP_REPORT
	} bhpq_op_t;

	// Branch conditions; a taken branch loads the target, else advance.
	typedef enum logic [3:0] {
		C_NEXT,
		C_ALWAYS,
		C_NO_REQ,
		C_POP,
		C_FULL,
		C_EMPTY,
		C_LAST,
		C_IDX_ZERO,
		C_UP_MOVE,
		C_DN_MOVE,
		C_NO_CHILD,
		C_OUT_FREE
	} bhpq_cond_t;

	typedef enum logic [4:0] {
		ST_FETCH,
		ST_DISPATCH,
		ST_PUSH,
		ST_PUSH_INIT,
		ST_UP_TEST,
		ST_UP_CMP,
		ST_PLACE,
		ST_POP,
		ST_POP_INIT,
		ST_POP_LOAD,
		ST_DN_TEST,
		ST_DN_CMP,
		ST_DN_END,
		ST_FULL,
		ST_EMPTY,
		ST_REPORT,
		ST_REPORT_WAIT
	} bhpq_step_t;

	typedef struct packed {
		bhpq_op_t   op;
		bhpq_cond_t cond;
		bhpq_step_t target;
	} bhpq_uword_t;

	// Status seen by the sequencer when it resolves a branch.
	typedef struct packed {
		logic req_valid;
		logic is_pop;
		logic full;
		logic empty;
		logic last;
		logic idx_zero;
		logic up_move;
		logic dn_move;
		logic no_child;
		logic out_free;
	} bhpq_flags_t;

	// Control store: the whole push and pop program.
	function automatic bhpq_uword_t bhpq_ucode(input bhpq_step_t step);
		bhpq_uword_t uw;
		unique case (step)
			ST_FETCH:       uw = '{OP_FETCH,     C_NO_REQ,   ST_FETCH};
			ST_DISPATCH:    uw = '{OP_NOP,       C_POP,      ST_POP};
			ST_PUSH:        uw = '{OP_NOP,       C_FULL,     ST_FULL};
			ST_PUSH_INIT:   uw = '{OP_PUSH_INIT, C_NEXT,     ST_FETCH};
			ST_UP_TEST:     uw = '{OP_RD_PARENT, C_IDX_ZERO, ST_PLACE};
			ST_UP_CMP:      uw = '{OP_UP_STEP,   C_UP_MOVE,  ST_UP_TEST};
			ST_PLACE:       uw = '{OP_PLACE,     C_ALWAYS,   ST_REPORT};
			ST_POP:         uw = '{OP_NOP,       C_EMPTY,    ST_EMPTY};
			ST_POP_INIT:    uw = '{OP_POP_INIT,  C_LAST,     ST_REPORT};
			ST_POP_LOAD:    uw = '{OP_LOAD_CUR,  C_NEXT,     ST_FETCH};
			ST_DN_TEST:     uw = '{OP_RD_CHILD,  C_NO_CHILD, ST_PLACE};
			ST_DN_CMP:      uw = '{OP_DN_STEP,   C_DN_MOVE,  ST_DN_TEST};
			ST_DN_END:      uw = '{OP_NOP,       C_ALWAYS,   ST_PLACE};
			ST_FULL:        uw = '{OP_SET_FULL,  C_ALWAYS,   ST_REPORT};
			ST_EMPTY:       uw = '{OP_SET_EMPTY, C_NEXT,     ST_FETCH};
			ST_REPORT:      uw = '{OP_REPORT,    C_OUT_FREE, ST_FETCH};
			ST_REPORT_WAIT: uw = '{OP_NOP,       C_ALWAYS,   ST_REPORT};
			default:        uw = '{OP_NOP,       C_ALWAYS,   ST_FETCH};
		endcase
		return uw;
	endfunction

endpackage

`default_nettype wire

// File: rtl/bhpq_if.sv
// ----------------------------------------------------------------------------
// bhpq_if
// Valid/ready channels for request and response words of the heap queue.
// ----------------------------------------------------------------------------
`default_nettype none

interface bhpq_req_if import bhpq_pkg::*; ();
	logic      valid;
	logic      ready;
	bhpq_req_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface bhpq_rsp_if import bhpq_pkg::*; ();
	logic      valid;
	logic      ready;
	bhpq_rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/binary_heap_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// binary_heap_priority_queue_unit
// Min-heap priority queue of key/payload entries, run by a microcoded sequencer.
// ----------------------------------------------------------------------------
// A push climbs the heap level by level while its parent holds a larger key,
// up to the root; a pop moves the last entry to the root and sinks it while a
// child holds a smaller key, down to a leaf. A pop on empty or a dropped push
// skips the heap walk. Throughput: one item at a time, next word taken the
// cycle after the result is loaded. Reset: arst_n empties the queue and drops
// any pending word.
`default_nettype none

module binary_heap_priority_queue_unit import bhpq_pkg::*; #(
	parameter int CAPACITY   = BHPQ_CAPACITY,
	parameter int ENTRY_BITS = BHPQ_ENTRY_BITS
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	bhpq_req_if.sink   req,
	bhpq_rsp_if.source rsp
);

	// The sequencer walks the control store and branches on datapath flags;
	// the datapath performs one action per control word.
	bhpq_uword_t uw;
	bhpq_flags_t flags;

	bhpq_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.uw     (uw)
	);

	// Hold the heap with a hole: the moving entry stays in a register and
	// only its final slot gets written, each move writes one entry.
	bhpq_dp #(
		.CAPACITY   (CAPACITY),
		.ENTRY_BITS (ENTRY_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.uw     (uw),
		.flags  (flags),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire

// File: rtl/bhpq_seq.sv
// ----------------------------------------------------------------------------
// bhpq_seq
// Step counter and branch logic that walk the control store.
// ----------------------------------------------------------------------------
`default_nettype none

module bhpq_seq import bhpq_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire bhpq_flags_t flags,
	output bhpq_uword_t      uw
);

	bhpq_step_t pc_q;
	logic       taken;

	assign uw = bhpq_ucode(pc_q);

	always_comb begin
		unique case (uw.cond)
			C_NEXT:     taken = 1'b0;
			C_ALWAYS:   taken = 1'b1;
			C_NO_REQ:   taken = !flags.req_valid;
			C_POP:      taken = flags.is_pop;
			C_FULL:     taken = flags.full;
			C_EMPTY:    taken = flags.empty;
			C_LAST:     taken = flags.last;
			C_IDX_ZERO: taken = flags.idx_zero;
			C_UP_MOVE:  taken = flags.up_move;
			C_DN_MOVE:  taken = flags.dn_move;
			C_NO_CHILD: taken = flags.no_child;
			C_OUT_FREE: taken = flags.out_free;
			default:    taken = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_FETCH;
		end else if (taken) begin
			pc_q <= uw.target;
		end else begin
			pc_q <= bhpq_step_t'(pc_q + 1'b1);
		end
	end

endmodule

`default_nettype wire

// File: rtl/bhpq_dp.sv
// ----------------------------------------------------------------------------
// bhpq_dp
// Heap store, index and entry registers, key compares and the output word.
// ----------------------------------------------------------------------------
`default_nettype none

module bhpq_dp import bhpq_pkg::*; #(
	parameter int CAPACITY   = BHPQ_CAPACITY,
	parameter int ENTRY_BITS = BHPQ_ENTRY_BITS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire bhpq_uword_t uw,
	output bhpq_flags_t      flags,
	bhpq_req_if.sink         req,
	bhpq_rsp_if.source       rsp
);

	localparam int PAY_W = ENTRY_BITS / 2;
	localparam int KEY_W = ENTRY_BITS - PAY_W;
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int EXT_W = IDX_W + 2;

	logic [ENTRY_BITS-1:0] heap_q [CAPACITY];

	logic [CNT_W-1:0]      cnt_q;
	logic [IDX_W-1:0]      idx_q;
	logic [ENTRY_BITS-1:0] cur_q;
	logic [ENTRY_BITS-1:0] top_q;
	logic [ENTRY_BITS-1:0] popped_q;
	logic [ENTRY_BITS-1:0] rda_q;
	logic [ENTRY_BITS-1:0] rdb_q;
	bhpq_status_t          status_q;
	bhpq_kind_t            kind_q;
	logic                  rsp_valid_q;
	bhpq_rsp_t             rsp_q;

	logic                  accept;
	logic                  out_free;
	logic [CNT_W-1:0]      cnt_m1;
	logic [IDX_W-1:0]      idx_m1;
	logic [IDX_W-1:0]      parent;
	logic [EXT_W-1:0]      child_a;
	logic [EXT_W-1:0]      child_b;
	logic [EXT_W-1:0]      cnt_x;
	logic                  has_b;
	logic                  sel_b;
	logic [ENTRY_BITS-1:0] child_e;
	logic [IDX_W-1:0]      child_i;
	logic [KEY_W-1:0]      key_cur;
	logic [KEY_W-1:0]      key_a;
	logic [KEY_W-1:0]      key_b;
	logic [KEY_W-1:0]      key_child;
	logic                  up_move;
	logic                  dn_move;
	logic [IDX_W-1:0]      rd_addr_a;
	logic                  wr_en;
	logic [ENTRY_BITS-1:0] wr_data;
	logic [ENTRY_BITS-1:0] new_entry;
	logic                  has_top;

	assign req.ready = (uw.op == OP_FETCH);
	assign accept    = req.valid && req.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;

	assign new_entry = {req.data.key[KEY_W-1:0], req.data.payload[PAY_W-1:0]};

	assign key_cur = cur_q[ENTRY_BITS-1:PAY_W];
	assign key_a   = rda_q[ENTRY_BITS-1:PAY_W];
	assign key_b   = rdb_q[ENTRY_BITS-1:PAY_W];

	// Parent of the hole on the way up: (idx - 1) / 2.
	assign cnt_m1 = cnt_q - CNT_W'(1);
	assign idx_m1 = idx_q - IDX_W'(1);
	assign parent = idx_m1 >> 1;

	// Children of the hole on the way down: 2*idx + 1 and 2*idx + 2.
	assign child_a = {1'b0, idx_q, 1'b1};
	assign child_b = child_a + EXT_W'(1);
	assign cnt_x   = EXT_W'(cnt_q);
	assign has_b   = child_b < cnt_x;

	// Strict compare: the right child wins only with a smaller key.
	assign sel_b     = has_b && (key_b < key_a);
	assign child_e   = sel_b ? rdb_q : rda_q;
	assign child_i   = sel_b ? child_b[IDX_W-1:0] : child_a[IDX_W-1:0];
	assign key_child = child_e[ENTRY_BITS-1:PAY_W];

	assign up_move = key_cur < key_a;
	assign dn_move = key_child < key_cur;

	always_comb begin
		case (uw.op)
			OP_POP_INIT: rd_addr_a = cnt_m1[IDX_W-1:0];
			OP_RD_CHILD: rd_addr_a = child_a[IDX_W-1:0];
			default:     rd_addr_a = parent;
		endcase
	end

	always_comb begin
		case (uw.op)
			OP_UP_STEP: begin
				wr_en   = up_move;
				wr_data = rda_q;
			end
			OP_DN_STEP: begin
				wr_en   = dn_move;
				wr_data = child_e;
			end
			OP_PLACE: begin
				wr_en   = 1'b1;
				wr_data = cur_q;
			end
			default: begin
				wr_en   = 1'b0;
				wr_data = cur_q;
			end
		endcase
	end

	// Heap store: one write port at the hole, two registered read ports.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			heap_q[idx_q] <= wr_data;
		end
		rda_q <= heap_q[rd_addr_a];
		rdb_q <= heap_q[child_b[IDX_W-1:0]];
	end

	assign flags.req_valid = req.valid;
	assign flags.is_pop    = (kind_q == KIND_POP);
	assign flags.full      = (cnt_q >= CNT_W'(CAPACITY));
	assign flags.empty     = (cnt_q == '0);
	assign flags.last      = (cnt_q == CNT_W'(1));
	assign flags.idx_zero  = (idx_q == '0);
	assign flags.up_move   = up_move;
	assign flags.dn_move   = dn_move;
	assign flags.no_child  = (child_a >= cnt_x);
	assign flags.out_free  = out_free;

	assign has_top = (cnt_q != '0);

	// Control: entry count and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (uw.op == OP_PUSH_INIT) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (uw.op == OP_POP_INIT) begin
				cnt_q <= cnt_m1;
			end
			if (uw.op == OP_REPORT && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q    <= new_entry;
			kind_q   <= req.data.kind;
			status_q <= STAT_DONE;
			popped_q <= '0;
		end
		case (uw.op)
			OP_PUSH_INIT: idx_q <= cnt_q[IDX_W-1:0];
			OP_UP_STEP:   if (up_move) idx_q <= parent;
			OP_POP_INIT: begin
				idx_q    <= '0;
				popped_q <= top_q;
			end
			OP_LOAD_CUR:  cur_q <= rda_q;
			OP_DN_STEP:   if (dn_move) idx_q <= child_i;
			OP_SET_FULL:  status_q <= STAT_FULL;
			OP_SET_EMPTY: status_q <= STAT_EMPTY;
			default: ;
		endcase
		// Mirror the root so peek needs no read.
		if (wr_en && idx_q == '0) begin
			top_q <= wr_data;
		end
		if (uw.op == OP_REPORT && out_free) begin
			rsp_q.status         <= status_q;
			rsp_q.popped_key     <= FIELD_W'(popped_q[ENTRY_BITS-1:PAY_W]);
			rsp_q.popped_payload <= FIELD_W'(popped_q[PAY_W-1:0]);
			rsp_q.top_valid      <= has_top;
			rsp_q.top_key        <= has_top ? FIELD_W'(top_q[ENTRY_BITS-1:PAY_W]) : '0;
			rsp_q.top_payload    <= has_top ? FIELD_W'(top_q[PAY_W-1:0]) : '0;
			rsp_q.entry_count    <= COUNT_W'(cnt_q);
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

endmodule

`default_nettype wire

// File: rtl/bhpq_checker.sv
// ----------------------------------------------------------------------------
// bhpq_checker
// Port-level checks on response words of the heap queue.
// ----------------------------------------------------------------------------
`default_nettype none

module bhpq_checker import bhpq_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      rsp_valid,
	input wire logic      rsp_ready,
	input wire bhpq_rsp_t rsp_data
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("response word changed while stalled");

	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.status == STAT_EMPTY |->
			rsp_data.entry_count == '0 && !rsp_data.top_valid &&
			rsp_data.popped_key == '0 && rsp_data.popped_payload == '0)
		else $error("pop on empty queue reported entries");

	a_no_top: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.top_valid |->
			rsp_data.entry_count == '0 && rsp_data.top_key == '0 &&
			rsp_data.top_payload == '0)
		else $error("empty queue showed a top entry");

	a_full_push: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.status == STAT_FULL |->
			rsp_data.top_valid && rsp_data.popped_key == '0 &&
			rsp_data.popped_payload == '0)
		else $error("dropped push reported a popped entry or no top");

endmodule

bind binary_heap_priority_queue_unit bhpq_checker u_bhpq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

`default_nettype wire
